@@ design/rrcm_pkg.sv @@
package rrcm_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int MAX_RESULTS    = 64;

    localparam int CH_W      = 2;
    localparam int SAMPLE_W  = 8;
    localparam int KIND_W    = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int CNT_W     = $clog2(MAX_RESULTS + 1);

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_MERGED   = 2'd0,
        KIND_FINISHED = 2'd1,
        KIND_DROPPED  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DONE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic            found;
        logic [CH_W-1:0] chan;
    } scan_res_t;

endpackage

@@ design/rrcm_scan.sv @@
module rrcm_scan #(
    parameter int CHANNELS = rrcm_pkg::CHANNELS_DEF
) (
    input  logic [CHANNELS-1:0]       empty,
    input  logic [CHANNELS-1:0]       closed,
    input  logic [rrcm_pkg::CH_W-1:0] turn,
    output rrcm_pkg::scan_res_t       res
);
    import rrcm_pkg::*;

    // walk the ring from the turn channel: report the first non-empty channel,
    // skip empty closed channels, stop at the first empty open one
    always_comb begin
        logic [CH_W:0]   idx;
        logic [CH_W-1:0] c;
        logic            done;
        res   = '0;
        done  = 1'b0;
        idx   = '0;
        c     = '0;
        for (int off = 0; off < CHANNELS; off++) begin
            idx = {1'b0, turn} + (CH_W+1)'(off);
            if (idx >= (CH_W+1)'(CHANNELS)) begin
                idx = idx - (CH_W+1)'(CHANNELS);
            end
            c = idx[CH_W-1:0];
            if (!done) begin
                if (!empty[c]) begin
                    res.found = 1'b1;
                    res.chan  = c;
                    done      = 1'b1;
                end else if (!closed[c]) begin
                    done = 1'b1;
                end
            end
        end
    end

endmodule

@@ design/round_robin_channel_merger.sv @@
// Merges byte streams from up to four channels in strict round-robin order. Each
// input word is either a byte for a channel (s_tuser = 0) or that channel's end of
// stream (s_tuser = 1). Bytes wait in a per-channel FIFO held in one shared buffer
// memory; after every input word the block drains in rotation from the turn channel,
// skipping channels that are empty and closed and stopping at one that is empty and
// still open. Each output word carries a kind in m_tuser (merged byte, all channels
// finished, byte dropped) and m_tlast marks the last word caused by one input word.
// Bytes to a full or closed FIFO, or to a channel number at or above CHANNELS, come
// back as dropped. Input words are taken one at a time: each passes through the states
// IDLE, SCAN, DONE and FLUSH, with SCAN and READ repeated for each merged byte (the read
// round trip through the buffer memory); a dropped byte or a completion word needs no
// extra state, and everything takes longer while m_tready is low.
module round_robin_channel_merger #(
    parameter int CHANNELS   = rrcm_pkg::CHANNELS_DEF,
    parameter int FIFO_DEPTH = rrcm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rrcm_pkg::S_TDATA_W-1:0] s_tdata,   // channel[1:0], sample[9:2]
    input  logic                           s_tuser,   // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rrcm_pkg::M_TDATA_W-1:0] m_tdata,   // out_channel[1:0], out_sample[9:2]
    output logic [rrcm_pkg::KIND_W-1:0]    m_tuser,   // kind
    output logic                           m_tlast    // last_of_run
);
    import rrcm_pkg::*;

    localparam int DEPTH_ALL = CHANNELS * FIFO_DEPTH;
    localparam int ADDR_W    = $clog2(DEPTH_ALL);
    localparam int HEAD_W    = $clog2(FIFO_DEPTH);
    localparam int FILL_W    = $clog2(FIFO_DEPTH + 1);
    localparam int PSUM_W    = FILL_W + 1;

    state_t state_reg, state_next;

    logic [FILL_W-1:0]   fill_reg [CHANNELS];
    logic [FILL_W-1:0]   fill_next [CHANNELS];
    logic [HEAD_W-1:0]   head_reg [CHANNELS];
    logic [HEAD_W-1:0]   head_next [CHANNELS];
    logic [CHANNELS-1:0] closed_reg, closed_next;
    logic [CH_W-1:0]     turn_reg, turn_next;
    logic                fin_reg, fin_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CH_W-1:0]     rd_chan_reg, rd_chan_next;

    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [CH_W-1:0]     out_chan_reg, out_chan_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                out_last_reg, out_last_next;

    logic                pend_valid_reg, pend_valid_next;
    kind_t               pend_kind_reg, pend_kind_next;
    logic [CH_W-1:0]     pend_chan_reg, pend_chan_next;
    logic [SAMPLE_W-1:0] pend_sample_reg, pend_sample_next;

    logic [SAMPLE_W-1:0] buf_mem [DEPTH_ALL];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;

    logic                s_action;
    logic [CH_W-1:0]     s_channel;
    logic [SAMPLE_W-1:0] s_sample;
    logic                ch_ok, drop_in;
    logic [PSUM_W-1:0]   wr_sum;
    logic [HEAD_W-1:0]   wr_pos;

    logic [CHANNELS-1:0] empty_vec;
    logic                all_done;
    scan_res_t           scan;
    logic [HEAD_W:0]     head_inc;
    logic                out_free, slot_ok;

    logic                gen_valid, flush;
    kind_t               gen_kind;
    logic [CH_W-1:0]     gen_chan;
    logic [SAMPLE_W-1:0] gen_sample;

    assign s_action  = s_tuser;
    assign s_channel = s_tdata[CH_W-1:0];
    assign s_sample  = s_tdata[CH_W+SAMPLE_W-1:CH_W];

    assign ch_ok   = {1'b0, s_channel} < (CH_W+1)'(CHANNELS);
    assign drop_in = !ch_ok || closed_reg[s_channel] ||
                     (fill_reg[s_channel] == FILL_W'(FIFO_DEPTH));

    // tail position = (head + fill) mod depth, head below depth, fill at most depth
    assign wr_sum  = PSUM_W'(head_reg[s_channel]) + PSUM_W'(fill_reg[s_channel]);
    assign wr_pos  = (wr_sum >= PSUM_W'(FIFO_DEPTH)) ?
                     HEAD_W'(wr_sum - PSUM_W'(FIFO_DEPTH)) : HEAD_W'(wr_sum);
    assign wr_addr = ADDR_W'(s_channel) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(wr_pos);

    always_comb begin
        all_done = 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
            empty_vec[c] = (fill_reg[c] == '0);
            if (!closed_reg[c] || !empty_vec[c]) begin
                all_done = 1'b0;
            end
        end
    end

    rrcm_scan #(
        .CHANNELS (CHANNELS)
    ) u_scan (
        .empty  (empty_vec),
        .closed (closed_reg),
        .turn   (turn_reg),
        .res    (scan)
    );

    assign head_inc = {1'b0, head_reg[scan.chan]} + (HEAD_W+1)'(1);
    assign out_free = !out_valid_reg || m_tready;
    // a new result can be staged if no word is pending or the pending word can move to the output
    assign slot_ok  = !pend_valid_reg || out_free;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        head_next    = head_reg;
        closed_next  = closed_reg;
        turn_next    = turn_reg;
        fin_next     = fin_reg;
        cnt_next     = cnt_reg;
        rd_chan_next = rd_chan_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        rd_addr      = '0;
        gen_valid    = 1'b0;
        gen_kind     = KIND_MERGED;
        gen_chan     = '0;
        gen_sample   = '0;
        flush        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cnt_next = '0;
                    if (s_action == ACT_BYTE) begin
                        if (drop_in) begin
                            gen_valid  = 1'b1;
                            gen_kind   = KIND_DROPPED;
                            gen_chan   = s_channel;
                            gen_sample = s_sample;
                            cnt_next   = CNT_W'(1);
                        end else begin
                            mem_we = 1'b1;
                            fill_next[s_channel] = fill_reg[s_channel] + FILL_W'(1);
                        end
                    end else if (ch_ok) begin
                        closed_next[s_channel] = 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan.found && cnt_reg < CNT_W'(MAX_RESULTS)) begin
                    mem_re  = 1'b1;
                    rd_addr = ADDR_W'(scan.chan) * ADDR_W'(FIFO_DEPTH) +
                              ADDR_W'(head_reg[scan.chan]);
                    head_next[scan.chan] = (head_inc == (HEAD_W+1)'(FIFO_DEPTH)) ?
                                           '0 : head_inc[HEAD_W-1:0];
                    fill_next[scan.chan] = fill_reg[scan.chan] - FILL_W'(1);
                    turn_next = (scan.chan == CH_W'(CHANNELS - 1)) ?
                                '0 : scan.chan + CH_W'(1);
                    rd_chan_next = scan.chan;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    state_next   = ST_READ;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                if (slot_ok) begin
                    gen_valid  = 1'b1;
                    gen_kind   = KIND_MERGED;
                    gen_chan   = rd_chan_reg;
                    gen_sample = rd_data_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (!fin_reg && cnt_reg < CNT_W'(MAX_RESULTS) && all_done) begin
                    if (slot_ok) begin
                        gen_valid  = 1'b1;
                        gen_kind   = KIND_FINISHED;
                        fin_next   = 1'b1;
                        state_next = ST_FLUSH;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    flush      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // one word is held back so the last word of a run can be marked
    always_comb begin
        out_valid_next   = out_valid_reg && !m_tready;
        out_kind_next    = out_kind_reg;
        out_chan_next    = out_chan_reg;
        out_sample_next  = out_sample_reg;
        out_last_next    = out_last_reg;
        pend_valid_next  = pend_valid_reg;
        pend_kind_next   = pend_kind_reg;
        pend_chan_next   = pend_chan_reg;
        pend_sample_next = pend_sample_reg;
        if (gen_valid) begin
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_kind_next   = pend_kind_reg;
                out_chan_next   = pend_chan_reg;
                out_sample_next = pend_sample_reg;
                out_last_next   = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_kind_next   = gen_kind;
            pend_chan_next   = gen_chan;
            pend_sample_next = gen_sample;
        end else if (flush) begin
            out_valid_next  = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_chan_next   = pend_chan_reg;
            out_sample_next = pend_sample_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            closed_reg     <= '0;
            turn_reg       <= '0;
            fin_reg        <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                fill_reg[c] <= '0;
                head_reg[c] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            head_reg       <= head_next;
            closed_reg     <= closed_next;
            turn_reg       <= turn_next;
            fin_reg        <= fin_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_chan_reg     <= rd_chan_next;
        out_kind_reg    <= out_kind_next;
        out_chan_reg    <= out_chan_next;
        out_sample_reg  <= out_sample_next;
        out_last_reg    <= out_last_next;
        pend_kind_reg   <= pend_kind_next;
        pend_chan_reg   <= pend_chan_next;
        pend_sample_reg <= pend_sample_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            buf_mem[wr_addr] <= s_sample;
        end
        if (mem_re) begin
            rd_data_reg <= buf_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - CH_W - SAMPLE_W)'(0), out_sample_reg, out_chan_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // no word may be held back while a new input word is taken
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("pending word left over at input accept");

    // read data is only used in ST_READ, which is entered only from ST_SCAN, where the read is issued
    a_read_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |->
            ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_READ))
        else $error("read data consumed without a read");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count beyond bound");

    // completion always closes a run
    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_FINISHED) |-> m_tlast)
        else $error("completion word not marked last");

    a_finish_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen_valid && gen_kind == KIND_FINISHED) |-> !fin_reg)
        else $error("completion reported twice");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import rrcm_pkg::*;

    localparam int CH_N        = CHANNELS_DEF;
    localparam int DEPTH       = FIFO_DEPTH_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 200;
    localparam int RANDOM_BYTES = 230;
    localparam int EXP_DEPTH   = 4096;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  chan;
        logic [7:0]  smp;
        logic        last;
    } merged_word_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    round_robin_channel_merger dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // merge state as the block should hold it
    logic [7:0]  chan_mem  [CH_N][DEPTH];
    int unsigned chan_fill [CH_N];
    int unsigned chan_head [CH_N];
    bit          chan_closed [CH_N];
    int unsigned turn_chan;
    bit          finish_sent;

    // expected words, a ring with separate write and read counts
    merged_word_t exp_words [EXP_DEPTH];
    int unsigned  exp_wr;
    int unsigned  exp_rd;
    int           mismatch_cnt;
    bit           calm_stretch;
    bit           hold_request;

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit take_break();
        if (calm_stretch)
            return 1'b0;
        return $urandom_range(99) < 13;
    endfunction

    function automatic merged_word_t word_of(kind_t kind, logic [1:0] chan, logic [7:0] smp,
                                             logic last);
        merged_word_t w;
        w.kind = kind;
        w.chan = chan;
        w.smp  = smp;
        w.last = last;
        return w;
    endfunction

    function automatic void add_word(kind_t kind, logic [1:0] chan, logic [7:0] smp);
        exp_words[exp_wr % EXP_DEPTH] = word_of(kind, chan, smp, 1'b0);
        exp_wr++;
    endfunction

    // applies one input word to the merge state and queues the words it causes
    function automatic void predict_merge(logic act, logic [1:0] ch, logic [7:0] smp);
        int          n;
        bit          progress;
        bit          all_done;
        int unsigned c;
        n = 0;
        if (act == ACT_BYTE) begin
            if (ch >= CH_N || chan_closed[ch] || chan_fill[ch] >= DEPTH) begin
                add_word(KIND_DROPPED, ch, smp);
                n++;
            end else begin
                chan_mem[ch][(chan_head[ch] + chan_fill[ch]) % DEPTH] = smp;
                chan_fill[ch]++;
            end
        end else if (ch < CH_N) begin
            chan_closed[ch] = 1'b1;
        end

        do begin
            progress = 1'b0;
            for (int off = 0; off < CH_N && n < MAX_RESULTS; off++) begin
                c = (turn_chan + off) % CH_N;
                if (chan_fill[c] == 0) begin
                    // closed and empty is skipped, open and empty ends the drain
                    if (chan_closed[c])
                        continue;
                    break;
                end
                add_word(KIND_MERGED, c[1:0], chan_mem[c][chan_head[c]]);
                n++;
                chan_head[c] = (chan_head[c] + 1) % DEPTH;
                chan_fill[c]--;
                turn_chan = (c + 1) % CH_N;
                progress = 1'b1;
                break;
            end
        end while (progress && n < MAX_RESULTS);

        all_done = 1'b1;
        for (int k = 0; k < CH_N; k++)
            if (!chan_closed[k] || chan_fill[k] != 0)
                all_done = 1'b0;
        if (!finish_sent && n < MAX_RESULTS && all_done) begin
            finish_sent = 1'b1;
            add_word(KIND_FINISHED, 2'd0, 8'd0);
            n++;
        end

        if (n > 0)
            exp_words[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
    endfunction

    task automatic send_word(input logic act, input logic [1:0] ch, input logic [7:0] smp);
        @(negedge aclk);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, smp, ch};
        do
            @(posedge aclk);
        while (!s_tready);
        predict_merge(act, ch, smp);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (exp_rd != exp_wr)
            @(posedge aclk);
    endtask

    task automatic test_sample_extremes();
        send_word(ACT_BYTE, 2'd0, 8'h00);
        send_word(ACT_BYTE, 2'd1, 8'hFF);
        send_word(ACT_BYTE, 2'd2, 8'hAA);
        send_word(ACT_BYTE, 2'd3, 8'h55);
    endtask

    // channel 0 is empty and open, so channel 2 fills up until it drops a byte
    task automatic test_full_fifo();
        for (int k = 0; k <= DEPTH; k++)
            send_word(ACT_BYTE, 2'd2, 8'($urandom_range(255)));
        send_word(ACT_BYTE, 2'd0, 8'($urandom_range(255)));
        send_word(ACT_BYTE, 2'd1, 8'($urandom_range(255)));
        send_word(ACT_BYTE, 2'd3, 8'($urandom_range(255)));
        wait_drained();
    endtask

    task automatic test_random_bytes(input int count);
        int         sent;
        int         burst;
        logic [1:0] ch;
        sent = 0;
        while (sent < count) begin
            calm_stretch = (sent >= 100 && sent < 160);
            ch = 2'($urandom_range(3));
            burst = ($urandom_range(99) < 25) ? $urandom_range(20, 2) : 1;
            repeat (burst) begin
                send_word(ACT_BYTE, ch, 8'($urandom_range(255)));
                sent++;
            end
        end
        calm_stretch = 1'b0;
        wait_drained();
    endtask

    // output held off long enough for the block to stall its input
    task automatic test_receiver_hold();
        hold_request = 1'b1;
        repeat (40)
            send_word(ACT_BYTE, 2'($urandom_range(3)), 8'($urandom_range(255)));
        wait_drained();
    endtask

    task automatic test_close_and_finish();
        logic [1:0] order [4];
        logic [1:0] t;
        int         j;
        for (int k = 0; k < 4; k++)
            order[k] = 2'(k);
        for (int k = 3; k > 0; k--) begin
            j = $urandom_range(k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (int k = 0; k < 4; k++) begin
            repeat ($urandom_range(8, 3))
                send_word(ACT_BYTE, 2'($urandom_range(3)), 8'($urandom_range(255)));
            send_word(ACT_END, order[k], 8'($urandom_range(255)));
            send_word(ACT_BYTE, order[k], 8'($urandom_range(255)));
            if (k == 0)
                send_word(ACT_END, order[k], 8'($urandom_range(255)));
        end
        wait_drained();
    endtask

    // everything is closed now: bytes drop, ends do nothing, no second completion
    task automatic test_after_finish();
        repeat (12)
            send_word(1'($urandom_range(1)), 2'($urandom_range(3)),
                      8'($urandom_range(255)));
        wait_drained();
    endtask

    initial begin : receiver
        int held;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge aclk);
                    held++;
                end
                hold_request = 1'b0;
            end
            m_tready <= !take_break();
        end
    end

    always @(posedge aclk) begin : check_words
        merged_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_rd == exp_wr) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected word: kind=%0d ch=%0d smp=%02h last=%0b",
                             m_tuser, m_tdata[1:0], m_tdata[9:2], m_tlast);
            end else begin
                want = exp_words[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_tuser !== want.kind || m_tdata[1:0] !== want.chan ||
                    m_tdata[9:2] !== want.smp || m_tlast !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: want %0d/%0d/%02h/%0b got %0d/%0d/%02h/%0b",
                                 want.kind, want.chan, want.smp, want.last,
                                 m_tuser, m_tdata[1:0], m_tdata[9:2], m_tlast);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        exp_wr   = 0;
        exp_rd   = 0;
        mismatch_cnt = 0;
        calm_stretch = 1'b0;
        hold_request = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_sample_extremes();
        test_full_fifo();
        test_random_bytes(RANDOM_BYTES);
        test_receiver_hold();
        test_close_and_finish();
        test_after_finish();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (exp_rd != exp_wr)
            $display("%0d expected words never arrived", exp_wr - exp_rd);
        if (mismatch_cnt == 0 && exp_rd == exp_wr)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
